/* hdl/ttag_pkg.sv */
`timescale 1ns / 1ps

package ttag_pkg;

  // Field widths of the words on the ports.
  localparam int X_W      = 12;
  localparam int Y_W      = 12;
  localparam int Z_W      = 9;
  localparam int LVL_W    = 4;
  localparam int DIM_W    = 13;
  localparam int DEP_W    = 4;
  localparam int PITCH_W  = 20;
  localparam int TB_W     = 5;
  localparam int OFF_W    = 40;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Internal widths.
  localparam int LOG_W    = 4;   // floor log2 of a 13 bit dimension
  localparam int POS_W    = 6;   // bit position inside a Morton index
  localparam int TERM_W   = 2 * DIM_W;
  localparam int AREA_W   = 27;  // sum of level areas in texels
  localparam int AREA_B_W = AREA_W + TB_W;
  localparam int ROW_W    = Y_W + PITCH_W;
  localparam int COL_W    = X_W + TB_W;

  // Largest floor log2 that a dimension register can give.
  localparam int DIM_LOG_MAX = DIM_W - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWIZZLED_MODE  = 3'd0,
    REG_TEXTURE_WIDTH  = 3'd1,
    REG_TEXTURE_HEIGHT = 3'd2,
    REG_DEPTH_LOG2     = 3'd3,
    REG_LINE_PITCH     = 3'd4,
    REG_TEXEL_BYTES    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic               swizzled_mode;
    logic [DIM_W-1:0]   texture_width;
    logic [DIM_W-1:0]   texture_height;
    logic [DEP_W-1:0]   depth_log2;
    logic [PITCH_W-1:0] line_pitch;
    logic [TB_W-1:0]    texel_bytes;
  } cfg_t;

  // One word travelling down the level pipeline.
  typedef struct packed {
    logic [X_W-1:0]    coord_x;
    logic [Y_W-1:0]    coord_y;
    logic [Z_W-1:0]    coord_z;
    logic [LVL_W-1:0]  level;
    logic [AREA_W-1:0] area;
  } item_t;

  // Floor log2 of a dimension; zero and one both give zero.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [DIM_W-1:0] v);
    logic [LOG_W-1:0] n;
    n = '0;
    for (int i = 1; i < DIM_W; i++) begin
      if (v[i]) begin
        n = LOG_W'(i);
      end
    end
    return n;
  endfunction

  function automatic logic [LOG_W-1:0] min_log(input logic [LOG_W-1:0] a,
                                               input logic [LOG_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // A halved dimension never drops below one.
  function automatic logic [DIM_W-1:0] floor1_dim(input logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : v;
  endfunction

  function automatic logic [PITCH_W-1:0] floor1_pitch(input logic [PITCH_W-1:0] v);
    return (v == '0) ? PITCH_W'(1) : v;
  endfunction

endpackage

/* hdl/ttag_level_stage.sv */
`timescale 1ns / 1ps

module ttag_level_stage
  import ttag_pkg::*;
#(
  parameter int LEVEL = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  cfg_t  cfg_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  logic [DIM_W-1:0]  width_lvl;
  logic [DIM_W-1:0]  height_lvl;
  logic [TERM_W-1:0] term;
  item_t             item_d;
  item_t             item_q;
  logic              valid_q;

  // Dimensions of this level, halved with a floor of one past level zero.
  always_comb begin
    if (LEVEL == 0) begin
      width_lvl  = cfg_i.texture_width;
      height_lvl = cfg_i.texture_height;
    end else begin
      width_lvl  = floor1_dim(cfg_i.texture_width >> LEVEL);
      height_lvl = floor1_dim(cfg_i.texture_height >> LEVEL);
    end
  end

  assign term = TERM_W'(width_lvl) * TERM_W'(height_lvl);

  // Add this level's area when the requested level lies beyond it.
  always_comb begin
    item_d = item_i;
    if (item_i.level > LVL_W'(LEVEL)) begin
      item_d.area = item_i.area + AREA_W'(term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hdl/ttag_addr_out.sv */
`timescale 1ns / 1ps

module ttag_addr_out
  import ttag_pkg::*;
#(
  parameter int MAX_SIZE_LOG2  = 12,
  parameter int MAX_DEPTH_LOG2 = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  cfg_t             cfg_i,
  input  logic             valid_i,
  input  item_t            item_i,
  output logic             valid_o,
  output logic [OFF_W-1:0] byte_offset_o
);

  localparam int LW_MAX = (MAX_SIZE_LOG2 < DIM_LOG_MAX) ? MAX_SIZE_LOG2 : DIM_LOG_MAX;
  localparam int LD_MAX = MAX_DEPTH_LOG2;
  localparam int ZN     = (LD_MAX < Z_W) ? LD_MAX : Z_W;
  localparam int IDX_W  = 2 * LW_MAX + LD_MAX;
  localparam int SWZ_W  = IDX_W + TB_W;

  logic [LOG_W-1:0]    lw;
  logic [LOG_W-1:0]    lh;
  logic [LOG_W-1:0]    ld;
  logic [PITCH_W-1:0]  pitch0_d;
  logic [PITCH_W-1:0]  pitch0_q;
  logic [PITCH_W-1:0]  pitch_lvl;
  logic [IDX_W-1:0]    idx_d;

  logic                valid_m_q;
  logic [AREA_B_W-1:0] area_b_q;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic [IDX_W-1:0]    idx_q;

  logic [SWZ_W-1:0]    swz_bytes;
  logic [OFF_W-1:0]    lin_bytes;
  logic                valid_f_q;
  logic [OFF_W-1:0]    off_q;

  // Interleave counts, saturated.
  always_comb begin
    lw = min_log(floor_log2(cfg_i.texture_width), LOG_W'(LW_MAX));
    lh = min_log(floor_log2(cfg_i.texture_height), LOG_W'(LW_MAX));
    ld = min_log(cfg_i.depth_log2, LOG_W'(LD_MAX));
  end

  // Row pitch of level zero; zero means width times texel size. It depends on
  // the configuration alone, which settles long before a word reaches this
  // stage, so it is held in a register of its own.
  always_comb begin
    if (cfg_i.line_pitch == '0) begin
      pitch0_d = PITCH_W'(cfg_i.texture_width) * PITCH_W'(cfg_i.texel_bytes);
    end else begin
      pitch0_d = cfg_i.line_pitch;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch0_q <= pitch0_d;
  end

  // Row pitch of the requested level.
  always_comb begin
    if (item_i.level == '0) begin
      pitch_lvl = pitch0_q;
    end else begin
      pitch_lvl = floor1_pitch(pitch0_q >> item_i.level);
    end
  end

  // Morton scatter: each coordinate bit goes to a position that counts the
  // bits taken before it in the x, y, z round order.
  always_comb begin
    logic [POS_W-1:0] pos;
    idx_d = '0;
    for (int r = 0; r < LW_MAX; r++) begin
      pos = POS_W'(min_log(LOG_W'(r), lw)) + POS_W'(min_log(LOG_W'(r), lh))
          + POS_W'(min_log(LOG_W'(r), ld));
      if (LOG_W'(r) < lw) begin
        idx_d = idx_d | (IDX_W'(item_i.coord_x[r]) << pos);
      end
      pos = POS_W'(min_log(LOG_W'(r + 1), lw)) + POS_W'(min_log(LOG_W'(r), lh))
          + POS_W'(min_log(LOG_W'(r), ld));
      if (LOG_W'(r) < lh) begin
        idx_d = idx_d | (IDX_W'(item_i.coord_y[r]) << pos);
      end
    end
    for (int r = 0; r < ZN; r++) begin
      pos = POS_W'(min_log(LOG_W'(r + 1), lw)) + POS_W'(min_log(LOG_W'(r + 1), lh))
          + POS_W'(min_log(LOG_W'(r), ld));
      if (LOG_W'(r) < ld) begin
        idx_d = idx_d | (IDX_W'(item_i.coord_z[r]) << pos);
      end
    end
  end

  // Product stage: row, column and level area terms, and the Morton index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
    end else if (adv_i) begin
      valid_m_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      area_b_q <= AREA_B_W'(item_i.area) * AREA_B_W'(cfg_i.texel_bytes);
      row_q    <= ROW_W'(item_i.coord_y) * ROW_W'(pitch_lvl);
      col_q    <= COL_W'(item_i.coord_x) * COL_W'(cfg_i.texel_bytes);
      idx_q    <= idx_d;
    end
  end

  // Output stage: sum for the linear layout, scaled index for the swizzled one.
  assign swz_bytes = SWZ_W'(idx_q) * SWZ_W'(cfg_i.texel_bytes);
  assign lin_bytes = OFF_W'(row_q) + OFF_W'(col_q) + OFF_W'(area_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_f_q <= 1'b0;
    end else if (adv_i) begin
      valid_f_q <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_m_q) begin
      off_q <= cfg_i.swizzled_mode ? OFF_W'(swz_bytes) : lin_bytes;
    end
  end

  assign valid_o       = valid_f_q;
  assign byte_offset_o = off_q;

endmodule

/* hdl/texture_texel_address_generator.sv */
`timescale 1ns / 1ps

// Texel address generator: turns a texel coordinate and a mip level into
// the texel's byte offset from the texture base, in linear pitched layout
// or in Morton swizzled layout as the configuration selects.
// Input words arrive on coord_*/mip_level with in_valid_i/in_ready_o, and
// result words leave on byte_offset_o with out_valid_o/out_ready_i.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i,
// one register per cycle; the user must do so only while no word is in
// flight, which the block does not enforce. Words pass one entry stage,
// one stage per level below the top one, adding its area, a product stage
// and an output stage. A new word is taken every cycle but while stalled.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o falls; no word is dropped or repeated.
// Reset empties the pipeline and returns the registers to linear layout,
// a 1 x 1 texture of four byte texels with a derived pitch.

module texture_texel_address_generator
  import ttag_pkg::*;
#(
  parameter int MAX_SIZE_LOG2  = 12,
  parameter int MAX_LEVELS     = 13,
  parameter int MAX_DEPTH_LOG2 = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [X_W-1:0]        coord_x_i,
  input  logic [Y_W-1:0]        coord_y_i,
  input  logic [Z_W-1:0]        coord_z_i,
  input  logic [LVL_W-1:0]      mip_level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OFF_W-1:0]      byte_offset_o
);

  localparam int LW_MAX = (MAX_SIZE_LOG2 < DIM_LOG_MAX) ? MAX_SIZE_LOG2 : DIM_LOG_MAX;
  localparam int IDX_W  = 2 * LW_MAX + MAX_DEPTH_LOG2;

  cfg_t                  cfg_q;
  logic                  adv;
  logic [LVL_W-1:0]      level_clamped;
  logic [MAX_LEVELS-1:0] stage_valid;
  item_t                 stage_item [MAX_LEVELS];
  logic                  entry_valid_q;
  item_t                 entry_item_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.swizzled_mode  <= 1'b0;
      cfg_q.texture_width  <= DIM_W'(1);
      cfg_q.texture_height <= DIM_W'(1);
      cfg_q.depth_log2     <= '0;
      cfg_q.line_pitch     <= '0;
      cfg_q.texel_bytes    <= TB_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SWIZZLED_MODE:  cfg_q.swizzled_mode  <= cfg_data_i[0];
        REG_TEXTURE_WIDTH:  cfg_q.texture_width  <= cfg_data_i[DIM_W-1:0];
        REG_TEXTURE_HEIGHT: cfg_q.texture_height <= cfg_data_i[DIM_W-1:0];
        REG_DEPTH_LOG2:     cfg_q.depth_log2     <= cfg_data_i[DEP_W-1:0];
        REG_LINE_PITCH:     cfg_q.line_pitch     <= cfg_data_i[PITCH_W-1:0];
        REG_TEXEL_BYTES:    cfg_q.texel_bytes    <= cfg_data_i[TB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves unless a result waits on a stalled receiver.
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Entry stage: register the word and clamp the level.
  assign level_clamped = (mip_level_i > LVL_W'(MAX_LEVELS - 1)) ?
                         LVL_W'(MAX_LEVELS - 1) : mip_level_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (adv) begin
      entry_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      entry_item_q.coord_x <= coord_x_i;
      entry_item_q.coord_y <= coord_y_i;
      entry_item_q.coord_z <= coord_z_i;
      entry_item_q.level   <= level_clamped;
      entry_item_q.area    <= '0;
    end
  end

  assign stage_valid[0] = entry_valid_q;
  assign stage_item[0]  = entry_item_q;

  // One stage per level that can lie below the requested one.
  for (genvar i = 0; i < MAX_LEVELS - 1; i++) begin : g_level
    ttag_level_stage #(
      .LEVEL (i)
    ) u_level (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .cfg_i   (cfg_q),
      .valid_i (stage_valid[i]),
      .item_i  (stage_item[i]),
      .valid_o (stage_valid[i+1]),
      .item_o  (stage_item[i+1])
    );
  end

  ttag_addr_out #(
    .MAX_SIZE_LOG2  (MAX_SIZE_LOG2),
    .MAX_DEPTH_LOG2 (MAX_DEPTH_LOG2)
  ) u_addr_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .cfg_i         (cfg_q),
    .valid_i       (stage_valid[MAX_LEVELS-1]),
    .item_i        (stage_item[MAX_LEVELS-1]),
    .valid_o       (out_valid_o),
    .byte_offset_o (byte_offset_o)
  );

  // A zero texel size gives a zero swizzled offset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg_q.swizzled_mode && (cfg_q.texel_bytes == '0)
    |-> byte_offset_o == '0)
    else $error("swizzled offset not zero for zero texel size");

  // Linear offsets stay well inside the output width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !cfg_q.swizzled_mode |-> byte_offset_o[OFF_W-1:34] == '0)
    else $error("linear offset out of range");

  // With one byte texels the swizzled offset is the bare Morton index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg_q.swizzled_mode && (cfg_q.texel_bytes == TB_W'(1))
    |-> (byte_offset_o >> IDX_W) == '0)
    else $error("Morton index wider than its interleave");

endmodule
